FILE: rtl/core/rtpau_pkg.sv
// Shared types and constants of the RTP AAC access-unit depacketiser.
`default_nettype none
package rtpau_pkg;

   localparam int BUF_BYTES_DEF   = 8192;
   localparam int MAX_FRAG_DEF    = 8191;
   localparam int MAX_AUS_DEF     = 64;

   localparam logic [5:0] SIZE_BITS_RST  = 6'd13;
   localparam logic [5:0] INDEX_BITS_RST = 6'd3;
   localparam logic [5:0] FIELD_MAX      = 6'd32;

   localparam int REQ_TDATA_W = 48;
   localparam int RSP_TDATA_W = 24;

   typedef enum logic {
      CSR_SIZE_BITS  = 1'b0,
      CSR_INDEX_BITS = 1'b1
   } csr_addr_type;

   typedef enum logic {
      KIND_BYTE = 1'b0,
      KIND_PULL = 1'b1
   } kind_type;

   typedef enum logic [3:0] {
      ST_READY         = 4'd0,
      ST_MORE_FRAG     = 4'd1,
      ST_SHORT         = 4'd2,
      ST_HDR_LONG      = 4'd3,
      ST_BAD_HDR       = 4'd4,
      ST_TOO_MANY      = 4'd5,
      ST_AU_BIG        = 4'd6,
      ST_FRAG_MISMATCH = 4'd7,
      ST_FRAG_MISSED   = 4'd8,
      ST_AU_OVER       = 4'd9,
      ST_NOTHING       = 4'd10
   } status_type;

   typedef enum logic [2:0] {
      PH_IDLE   = 3'd0,
      PH_LEN_LO = 3'd1,
      PH_HDR    = 3'd2,
      PH_DATA   = 3'd3,
      PH_SKIP   = 3'd4
   } phase_type;

   typedef enum logic [1:0] {
      ENG_RUN   = 2'd0,
      ENG_PSIZE = 2'd1,
      ENG_PBYTE = 2'd2,
      ENG_PLOOK = 2'd3
   } eng_type;

   typedef struct packed {
      kind_type    kind;
      logic [7:0]  byte_val;
      logic        first;
      logic        last;
      logic        marker;
      logic [31:0] ts;
   } item_type;

   typedef struct packed {
      logic        is_status;
      status_type  status;
      logic [7:0]  data;
      logic        au_last;
      logic        frame_last;
      logic [6:0]  au_count;
   } result_type;

endpackage
`default_nettype wire

FILE: rtl/core/rtpau_front.sv
// Request front end: classifies requests and queues them for the engine.
`default_nettype none
module rtpau_front (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 req_tvalid,
   output logic                                req_tready,
   input  wire  [rtpau_pkg::REQ_TDATA_W-1:0]   req_tdata,
   input  wire                                 req_tuser,
   input  wire                                 req_tlast,
   output logic                                head_valid,
   output rtpau_pkg::item_type                 head,
   input  wire                                 pop
);

   rtpau_pkg::item_type q_ff [2];
   rtpau_pkg::item_type item_in;
   logic                wr_ptr_ff, wr_ptr_in;
   logic                rd_ptr_ff, rd_ptr_in;
   logic [1:0]          count_ff, count_in;
   logic                push;

   assign req_tready = (count_ff != 2'd2);
   assign push       = req_tvalid && req_tready;
   assign head_valid = (count_ff != 2'd0);
   assign head       = q_ff[rd_ptr_ff];

   always_comb begin
      item_in.kind     = req_tuser ? rtpau_pkg::KIND_PULL : rtpau_pkg::KIND_BYTE;
      item_in.byte_val = req_tdata[7:0];
      item_in.first    = req_tdata[8];
      item_in.last     = req_tlast;
      item_in.marker   = req_tdata[9];
      item_in.ts       = req_tdata[41:10];
   end

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= item_in;
      end
   end

endmodule
`default_nettype wire

FILE: rtl/core/rtpau_back.sv
// Engine: header parsing, AU buffering, fragment reassembly, draining, result register.
`default_nettype none
module rtpau_back #(
   parameter int BUF_BYTES         = rtpau_pkg::BUF_BYTES_DEF,
   parameter int MAX_FRAGMENTED_AU = rtpau_pkg::MAX_FRAG_DEF,
   parameter int MAX_AUS           = rtpau_pkg::MAX_AUS_DEF
) (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    csr_we,
   input  wire                    csr_addr,
   input  wire  [5:0]             csr_wdata,
   input  wire                    head_valid,
   input  rtpau_pkg::item_type    head,
   output logic                   pop,
   output logic                   rsp_valid,
   input  wire                    rsp_ready,
   output rtpau_pkg::result_type  rsp
);

   localparam int BAW = (BUF_BYTES > 1) ? $clog2(BUF_BYTES) : 1;
   localparam int BPW = $clog2(BUF_BYTES + 1);
   localparam int WPW = $clog2(MAX_FRAGMENTED_AU + 1);
   localparam int TAW = (MAX_AUS > 1) ? $clog2(MAX_AUS) : 1;
   localparam int CW  = $clog2(MAX_AUS + 2);

   function automatic logic [5:0] clamp_w(input logic [5:0] w);
      clamp_w = (w > rtpau_pkg::FIELD_MAX) ? rtpau_pkg::FIELD_MAX : w;
   endfunction

   function automatic logic [BPW-1:0] cap_buf(input logic [32:0] v);
      cap_buf = (v > 33'(BUF_BYTES)) ? BPW'(BUF_BYTES) : BPW'(v);
   endfunction

   // configuration
   logic [5:0] size_bits_ff, size_bits_in;
   logic [5:0] index_bits_ff, index_bits_in;

   // header parser
   rtpau_pkg::phase_type  phase_ff, phase_in;
   rtpau_pkg::eng_type    eng_ff, eng_in;
   rtpau_pkg::status_type skip_ff, skip_in;
   logic [15:0]    hbl_ff, hbl_in;
   logic [39:0]    acc_ff, acc_in;
   logic [5:0]     acc_bits_ff, acc_bits_in;
   logic [16:0]    bits_ff, bits_in;
   logic           sel_ff, sel_in;
   logic           fed_ff, fed_in;
   logic [CW-1:0]  fields_ff, fields_in;
   logic [13:0]    seen_ff, seen_in;
   logic [13:0]    need_ff, need_in;
   logic [5:0]     sw_ff, sw_in;
   logic [5:0]     iw_ff, iw_in;
   logic [CW-1:0]  au_exp_ff, au_exp_in;
   logic [31:0]    data_len_ff, data_len_in;
   logic [31:0]    size0_ff, size0_in;

   // fragments and frame
   logic [WPW-1:0] wp_ff, wp_in;
   logic [WPW-1:0] frag_exp_ff, frag_exp_in;
   logic [31:0]    frag_ts_ff, frag_ts_in;
   logic [BPW-1:0] rp_ff, rp_in;
   logic [BPW-1:0] fend_ff, fend_in;
   logic [CW-1:0]  au_total_ff, au_total_in;
   logic [CW-1:0]  idx_ff, idx_in;
   logic [BPW-1:0] left_ff, left_in;
   logic           active_ff, active_in;
   logic [7:0]     pend_ff, pend_in;

   // result register
   logic                  rsp_valid_ff, rsp_valid_in;
   rtpau_pkg::result_type rsp_ff, rsp_in;
   rtpau_pkg::result_type res;
   logic                  emit;

   // memories
   logic [31:0]    tbl_mem [MAX_AUS];
   logic [31:0]    tbl_rd_ff;
   logic           tbl_we, tbl_re;
   logic [TAW-1:0] tbl_waddr, tbl_raddr;
   logic [31:0]    tbl_wdata;
   logic [7:0]     buf_mem [BUF_BYTES];
   logic [7:0]     buf_rd_ff;
   logic           buf_we, buf_re;
   logic [BAW-1:0] buf_waddr;
   logic [7:0]     buf_wdata;

   // decode
   logic           out_free, is_pull, run_pull, run_byte;
   logic           p_none, p_end, p_size, p_byte;
   logic [CW-1:0]  idx1;
   logic           idx1_end;
   logic           sz_zero, sz_big;
   logic           last_byte;
   logic [6:0]     hs;
   logic [39:0]    acc_view;
   logic [6:0]     ab_sum;
   logic [5:0]     ab_view;
   logic [5:0]     fw;
   logic           can_ext;
   logic [39:0]    ext_sh;
   logic [31:0]    ext_mask;
   logic [31:0]    ext_val;
   logic [15:0]    hbl_lo;
   logic [16:0]    need_sum;
   logic           hdr_ok;
   logic [32:0]    wr_sum;
   logic [32:0]    fin_sum;
   logic [WPW-1:0] fe_eff;
   logic [31:0]    ft_eff;
   logic [WPW-1:0] wp_new;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign is_pull   = (head.kind == rtpau_pkg::KIND_PULL);
   assign run_pull  = (eng_ff == rtpau_pkg::ENG_RUN) && head_valid && is_pull && out_free;
   assign run_byte  = (eng_ff == rtpau_pkg::ENG_RUN) && head_valid && !is_pull
                      && (out_free || !head.last);
   assign p_none    = !active_ff;
   assign p_end     = active_ff && (left_ff == '0) && (idx_ff >= au_total_ff);
   assign p_size    = active_ff && (left_ff == '0) && (idx_ff < au_total_ff);
   assign p_byte    = active_ff && (left_ff != '0);
   assign idx1      = idx_ff + CW'(1);
   assign idx1_end  = (idx1 >= au_total_ff);
   assign sz_zero   = (tbl_rd_ff == 32'd0);
   assign sz_big    = tbl_rd_ff > 32'(fend_ff - rp_ff);
   assign last_byte = (left_ff == BPW'(1));

   assign hs       = 7'(sw_ff) + 7'(iw_ff);
   assign acc_view = fed_ff ? acc_ff : {acc_ff[31:0], head.byte_val};
   assign ab_sum   = 7'(acc_bits_ff) + 7'd8;
   assign ab_view  = fed_ff ? acc_bits_ff : ((ab_sum > 7'd40) ? 6'd40 : ab_sum[5:0]);
   assign fw       = sel_ff ? iw_ff : sw_ff;
   assign can_ext  = (hs != 7'd0) && (bits_ff < 17'(hbl_ff)) && (ab_view >= fw);
   assign ext_sh   = acc_view >> (ab_view - fw);
   assign ext_mask = 32'((33'd1 << fw) - 33'd1);
   assign ext_val  = ext_sh[31:0] & ext_mask;
   assign hbl_lo   = {hbl_ff[15:8], head.byte_val};
   assign need_sum = 17'(hbl_lo) + 17'd7;
   assign hdr_ok   = (hs != 7'd0) && (bits_ff == 17'(hbl_ff))
                     && (!sel_ff || (sw_ff == 6'd0) || (iw_ff == 6'd0));
   assign wr_sum   = 33'(wp_ff) + 33'(data_len_ff);

   // engine state
   always_comb begin
      eng_in = eng_ff;
      unique case (eng_ff)
         rtpau_pkg::ENG_RUN: begin
            if (run_pull && p_size) begin
               eng_in = rtpau_pkg::ENG_PSIZE;
            end else if (run_pull && p_byte) begin
               eng_in = rtpau_pkg::ENG_PBYTE;
            end
         end
         rtpau_pkg::ENG_PSIZE: begin
            if (out_free) begin
               if (sz_zero && !idx1_end) begin
                  eng_in = rtpau_pkg::ENG_PSIZE;
               end else if (!sz_zero && !sz_big) begin
                  eng_in = rtpau_pkg::ENG_PBYTE;
               end else begin
                  eng_in = rtpau_pkg::ENG_RUN;
               end
            end
         end
         rtpau_pkg::ENG_PBYTE: begin
            if (out_free) begin
               eng_in = (last_byte && !idx1_end) ? rtpau_pkg::ENG_PLOOK : rtpau_pkg::ENG_RUN;
            end
         end
         rtpau_pkg::ENG_PLOOK: begin
            if (out_free) begin
               eng_in = (sz_zero && !idx1_end) ? rtpau_pkg::ENG_PLOOK : rtpau_pkg::ENG_RUN;
            end
         end
         default: eng_in = rtpau_pkg::ENG_RUN;
      endcase
   end

   // datapath
   always_comb begin
      size_bits_in  = size_bits_ff;
      index_bits_in = index_bits_ff;
      phase_in      = phase_ff;
      skip_in       = skip_ff;
      hbl_in        = hbl_ff;
      acc_in        = acc_ff;
      acc_bits_in   = acc_bits_ff;
      bits_in       = bits_ff;
      sel_in        = sel_ff;
      fed_in        = fed_ff;
      fields_in     = fields_ff;
      seen_in       = seen_ff;
      need_in       = need_ff;
      sw_in         = sw_ff;
      iw_in         = iw_ff;
      au_exp_in     = au_exp_ff;
      data_len_in   = data_len_ff;
      size0_in      = size0_ff;
      wp_in         = wp_ff;
      frag_exp_in   = frag_exp_ff;
      frag_ts_in    = frag_ts_ff;
      rp_in         = rp_ff;
      fend_in       = fend_ff;
      au_total_in   = au_total_ff;
      idx_in        = idx_ff;
      left_in       = left_ff;
      active_in     = active_ff;
      pend_in       = pend_ff;
      pop           = 1'b0;
      emit          = 1'b0;
      res           = '0;
      tbl_we        = 1'b0;
      tbl_waddr     = TAW'(fields_ff);
      tbl_wdata     = ext_val;
      tbl_re        = 1'b0;
      tbl_raddr     = TAW'(idx_ff);
      buf_we        = 1'b0;
      buf_waddr     = BAW'(wr_sum);
      buf_wdata     = head.byte_val;
      buf_re        = 1'b0;
      fin_sum       = '0;
      fe_eff        = '0;
      ft_eff        = '0;
      wp_new        = '0;

      if (csr_we) begin
         if (csr_addr == rtpau_pkg::CSR_SIZE_BITS) begin
            size_bits_in = csr_wdata;
         end else begin
            index_bits_in = csr_wdata;
         end
      end

      if (run_byte) begin
         pop = 1'b1;
         if (head.first || (phase_ff == rtpau_pkg::PH_IDLE)) begin
            active_in = 1'b0;
            hbl_in    = {head.byte_val, 8'd0};
            phase_in  = rtpau_pkg::PH_LEN_LO;
         end else if (phase_ff == rtpau_pkg::PH_LEN_LO) begin
            hbl_in      = hbl_lo;
            sw_in       = clamp_w(size_bits_ff);
            iw_in       = clamp_w(index_bits_ff);
            acc_in      = '0;
            acc_bits_in = '0;
            bits_in     = '0;
            fields_in   = '0;
            sel_in      = 1'b0;
            fed_in      = 1'b0;
            seen_in     = '0;
            need_in     = need_sum[16:3];
            if (32'(hbl_lo) > 32'(BUF_BYTES)) begin
               phase_in = rtpau_pkg::PH_SKIP;
               skip_in  = rtpau_pkg::ST_HDR_LONG;
            end else if (need_sum[16:3] == 14'd0) begin
               phase_in = rtpau_pkg::PH_SKIP;
               skip_in  = rtpau_pkg::ST_BAD_HDR;
            end else begin
               phase_in = rtpau_pkg::PH_HDR;
            end
         end else if (phase_ff == rtpau_pkg::PH_HDR) begin
            acc_in = acc_view;
            if (can_ext) begin
               // one header field per cycle while the engine runs, the byte stays at the head
               pop         = 1'b0;
               acc_bits_in = ab_view - fw;
               bits_in     = bits_ff + 17'(fw);
               sel_in      = ~sel_ff;
               fed_in      = 1'b1;
               if (!sel_ff) begin
                  tbl_we = (fields_ff < CW'(MAX_AUS));
                  if (fields_ff == '0) begin
                     size0_in = ext_val;
                  end
                  if (fields_ff != CW'(MAX_AUS + 1)) begin
                     fields_in = fields_ff + CW'(1);
                  end
               end
            end else begin
               acc_bits_in = ab_view;
               fed_in      = 1'b0;
               seen_in     = seen_ff + 14'd1;
               if ((seen_ff + 14'd1) >= need_ff) begin
                  if (!hdr_ok || (fields_ff == '0)) begin
                     phase_in = rtpau_pkg::PH_SKIP;
                     skip_in  = rtpau_pkg::ST_BAD_HDR;
                  end else if (fields_ff > CW'(MAX_AUS)) begin
                     phase_in = rtpau_pkg::PH_SKIP;
                     skip_in  = rtpau_pkg::ST_TOO_MANY;
                  end else begin
                     if (fields_ff != CW'(1)) begin
                        wp_in       = '0;
                        frag_exp_in = '0;
                     end
                     au_exp_in   = fields_ff;
                     data_len_in = '0;
                     phase_in    = rtpau_pkg::PH_DATA;
                  end
               end
            end
         end else if (phase_ff == rtpau_pkg::PH_DATA) begin
            buf_we = (wr_sum < 33'(BUF_BYTES));
            if (data_len_ff != 32'hFFFF_FFFF) begin
               data_len_in = data_len_ff + 32'd1;
            end
         end

         if (pop && head.last) begin
            emit          = 1'b1;
            res.is_status = 1'b1;
            if ((phase_in == rtpau_pkg::PH_LEN_LO) || (phase_in == rtpau_pkg::PH_HDR)) begin
               res.status = rtpau_pkg::ST_SHORT;
            end else if (phase_in == rtpau_pkg::PH_SKIP) begin
               res.status = skip_in;
            end else begin
               fin_sum = 33'(wp_in) + 33'(data_len_in);
               if ((au_exp_in == CW'(1)) && (data_len_in < size0_in)) begin
                  if ((wp_in == '0) && (size0_in > 32'(MAX_FRAGMENTED_AU))) begin
                     res.status = rtpau_pkg::ST_AU_BIG;
                  end else begin
                     fe_eff = (wp_in == '0) ? WPW'(size0_in) : frag_exp_in;
                     ft_eff = (wp_in == '0) ? head.ts : frag_ts_ff;
                     if (wp_in == '0) begin
                        frag_ts_in = head.ts;
                     end
                     if ((ft_eff != head.ts) || (size0_in != 32'(fe_eff))
                         || (fin_sum > 33'(MAX_FRAGMENTED_AU))) begin
                        wp_in       = '0;
                        frag_exp_in = '0;
                        res.status  = rtpau_pkg::ST_FRAG_MISMATCH;
                     end else begin
                        wp_new      = WPW'(fin_sum);
                        frag_exp_in = fe_eff;
                        if (!head.marker) begin
                           wp_in      = wp_new;
                           res.status = rtpau_pkg::ST_MORE_FRAG;
                        end else if (wp_new != fe_eff) begin
                           wp_in      = '0;
                           res.status = rtpau_pkg::ST_FRAG_MISSED;
                        end else begin
                           wp_in        = '0;
                           rp_in        = '0;
                           fend_in      = cap_buf(33'(fe_eff));
                           au_total_in  = CW'(1);
                           idx_in       = '0;
                           left_in      = '0;
                           active_in    = 1'b1;
                           res.status   = rtpau_pkg::ST_READY;
                           res.au_count = 7'd1;
                        end
                     end
                  end
               end else if (data_len_in < size0_in) begin
                  res.status = rtpau_pkg::ST_AU_OVER;
               end else begin
                  rp_in        = BPW'(wp_in);
                  fend_in      = cap_buf(fin_sum);
                  au_total_in  = au_exp_in;
                  idx_in       = '0;
                  left_in      = '0;
                  active_in    = 1'b1;
                  wp_in        = '0;
                  frag_exp_in  = '0;
                  res.status   = rtpau_pkg::ST_READY;
                  res.au_count = 7'(au_exp_in);
               end
            end
            phase_in = rtpau_pkg::PH_IDLE;
         end
      end

      if (run_pull) begin
         if (p_none || p_end) begin
            pop           = 1'b1;
            emit          = 1'b1;
            active_in     = 1'b0;
            res.is_status = 1'b1;
            res.status    = rtpau_pkg::ST_NOTHING;
         end else if (p_size) begin
            tbl_re    = 1'b1;
            tbl_raddr = TAW'(idx_ff);
         end else begin
            buf_re = 1'b1;
         end
      end

      if ((eng_ff == rtpau_pkg::ENG_PSIZE) && out_free) begin
         if (sz_zero) begin
            idx_in = idx1;
            if (idx1_end) begin
               pop           = 1'b1;
               emit          = 1'b1;
               active_in     = 1'b0;
               res.is_status = 1'b1;
               res.status    = rtpau_pkg::ST_NOTHING;
            end else begin
               tbl_re    = 1'b1;
               tbl_raddr = TAW'(idx1);
            end
         end else if (sz_big) begin
            pop           = 1'b1;
            emit          = 1'b1;
            active_in     = 1'b0;
            res.is_status = 1'b1;
            res.status    = rtpau_pkg::ST_NOTHING;
         end else begin
            left_in = BPW'(tbl_rd_ff);
            buf_re  = 1'b1;
         end
      end

      if ((eng_ff == rtpau_pkg::ENG_PBYTE) && out_free) begin
         rp_in   = rp_ff + BPW'(1);
         left_in = left_ff - BPW'(1);
         if (last_byte) begin
            idx_in = idx1;
            if (idx1_end) begin
               pop            = 1'b1;
               emit           = 1'b1;
               active_in      = 1'b0;
               res.data       = buf_rd_ff;
               res.au_last    = 1'b1;
               res.frame_last = 1'b1;
            end else begin
               // look ahead for a further non-empty AU before flagging the byte
               pend_in   = buf_rd_ff;
               tbl_re    = 1'b1;
               tbl_raddr = TAW'(idx1);
            end
         end else begin
            pop      = 1'b1;
            emit     = 1'b1;
            res.data = buf_rd_ff;
         end
      end

      if ((eng_ff == rtpau_pkg::ENG_PLOOK) && out_free) begin
         if (!sz_zero) begin
            pop         = 1'b1;
            emit        = 1'b1;
            res.data    = pend_ff;
            res.au_last = 1'b1;
         end else begin
            idx_in = idx1;
            if (idx1_end) begin
               pop            = 1'b1;
               emit           = 1'b1;
               active_in      = 1'b0;
               res.data       = pend_ff;
               res.au_last    = 1'b1;
               res.frame_last = 1'b1;
            end else begin
               tbl_re    = 1'b1;
               tbl_raddr = TAW'(idx1);
            end
         end
      end

      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_in       = res;
      end else begin
         rsp_valid_in = rsp_valid_ff && !rsp_ready;
         rsp_in       = rsp_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         size_bits_ff  <= rtpau_pkg::SIZE_BITS_RST;
         index_bits_ff <= rtpau_pkg::INDEX_BITS_RST;
         phase_ff      <= rtpau_pkg::PH_IDLE;
         eng_ff        <= rtpau_pkg::ENG_RUN;
         fed_ff        <= 1'b0;
         wp_ff         <= '0;
         frag_exp_ff   <= '0;
         frag_ts_ff    <= '0;
         active_ff     <= 1'b0;
         left_ff       <= '0;
         idx_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         size_bits_ff  <= size_bits_in;
         index_bits_ff <= index_bits_in;
         phase_ff      <= phase_in;
         eng_ff        <= eng_in;
         fed_ff        <= fed_in;
         wp_ff         <= wp_in;
         frag_exp_ff   <= frag_exp_in;
         frag_ts_ff    <= frag_ts_in;
         active_ff     <= active_in;
         left_ff       <= left_in;
         idx_ff        <= idx_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      skip_ff     <= skip_in;
      hbl_ff      <= hbl_in;
      acc_ff      <= acc_in;
      acc_bits_ff <= acc_bits_in;
      bits_ff     <= bits_in;
      sel_ff      <= sel_in;
      fields_ff   <= fields_in;
      seen_ff     <= seen_in;
      need_ff     <= need_in;
      sw_ff       <= sw_in;
      iw_ff       <= iw_in;
      au_exp_ff   <= au_exp_in;
      data_len_ff <= data_len_in;
      size0_ff    <= size0_in;
      rp_ff       <= rp_in;
      fend_ff     <= fend_in;
      au_total_ff <= au_total_in;
      pend_ff     <= pend_in;
      rsp_ff      <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (tbl_we) begin
         tbl_mem[tbl_waddr] <= tbl_wdata;
      end
      if (tbl_re) begin
         tbl_rd_ff <= tbl_mem[tbl_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (buf_we) begin
         buf_mem[buf_waddr] <= buf_wdata;
      end
      if (buf_re) begin
         buf_rd_ff <= buf_mem[BAW'(rp_ff)];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule
`default_nettype wire

FILE: rtl/core/rtp_aac_au_depacketizer.sv
// RTP AAC access-unit depacketiser (AU-header section parsing) top level.
//
// req channel: one request per cycle at most. tuser 0 carries one RTP payload
// byte, tuser 1 asks for the next buffered AU byte. tlast marks the last
// payload byte of a packet; marker and timestamp are taken from that byte.
// rsp channel: one result per packet (status, AU count when ready) and one
// result per pull (a data byte with AU and frame end flags, or a status).
// csr port: register 0 sets the AU-size width, register 1 the AU-index width.
// Work per request: a length or data byte is consumed as it is taken; an AU-header
// byte stays at the head until every header field it completes has been taken;
// a pull with no frame returns a status, a data pull reads the byte buffer, and
// a pull also reads the AU-size table at the start of an AU, for each empty AU
// passed, and for the look-ahead after an AU's last byte. Table and byte buffer
// are memories with one write port and one registered read port.
// Results are registered; a request taken into an empty queue is at the head
// of the queue the cycle after it is taken.
// A two-entry request queue decouples intake from the engine; a result
// register decouples the engine from the receiver. A stalled receiver holds
// the result; the engine stops once it needs the register, then the queue
// fills and req_tready drops. Reset empties both, sets widths to 13 and 3.
`default_nettype none
module rtp_aac_au_depacketizer #(
   parameter int BUF_BYTES         = rtpau_pkg::BUF_BYTES_DEF,
   parameter int MAX_FRAGMENTED_AU = rtpau_pkg::MAX_FRAG_DEF,
   parameter int MAX_AUS           = rtpau_pkg::MAX_AUS_DEF
) (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                req_tvalid,
   output logic                               req_tready,
   // payload_byte[7:0], packet_first[8], marker[9], rtp_timestamp[41:10], zero
   input  wire  [rtpau_pkg::REQ_TDATA_W-1:0]  req_tdata,
   // action
   input  wire                                req_tuser,
   input  wire                                req_tlast,
   output logic                               rsp_tvalid,
   input  wire                                rsp_tready,
   // status[3:0], data_byte[11:4], frame_last[12], au_count[19:13], zero
   output logic [rtpau_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   // is_status
   output logic                               rsp_tuser,
   output logic                               rsp_tlast,
   input  wire                                csr_we,
   input  wire                                csr_addr,
   input  wire  [5:0]                         csr_wdata
);

   logic                  head_valid;
   rtpau_pkg::item_type   head;
   logic                  pop;
   rtpau_pkg::result_type rsp;

   rtpau_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .head_valid (head_valid),
      .head       (head),
      .pop        (pop)
   );

   rtpau_back #(
      .BUF_BYTES         (BUF_BYTES),
      .MAX_FRAGMENTED_AU (MAX_FRAGMENTED_AU),
      .MAX_AUS           (MAX_AUS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .head_valid (head_valid),
      .head       (head),
      .pop        (pop),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp        (rsp)
   );

   assign rsp_tdata = {4'd0, rsp.au_count, rsp.frame_last, rsp.data, rsp.status};
   assign rsp_tuser = rsp.is_status;
   assign rsp_tlast = rsp.au_last;

endmodule
`default_nettype wire

FILE: rtl/core/rtpau_checker.sv
// Port-level checks on the depacketiser's result channel, bound to the top level.
`default_nettype none
module rtpau_checker (
   input wire        clock,
   input wire        reset,
   input wire        rsp_tvalid,
   input wire        rsp_tready,
   input wire [23:0] rsp_tdata,
   input wire        rsp_tuser,
   input wire        rsp_tlast
);

   a_hold_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result dropped while stalled");

   a_reset_empty: assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_tvalid)
      else $error("result present straight after reset");

   a_data_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata[3:0] == 4'd0 && rsp_tdata[19:13] == 7'd0)
      else $error("data byte carries status or count");

   a_status_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> !rsp_tlast && !rsp_tdata[12] && rsp_tdata[11:4] == 8'd0)
      else $error("status result carries data flags");

endmodule

bind rtp_aac_au_depacketizer rtpau_checker u_rtpau_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);
`default_nettype wire
